/* rtl/core/assert_macros.svh */
// Assertion macros shared by the scanner response parser RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock edge, masked while reset is asserted (active low).
`define SRP_ASSERT(lbl, clk_i, rstn_i, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) prop) else $error(msg);

// Concurrent check on the rising clock edge that also holds across reset.
`define SRP_ASSERT_ALWAYS(lbl, clk_i, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* rtl/core/srp_pkg.sv */
// Shared types, codes and reply tables for the scanner response parser.
`timescale 1ns / 1ps

package srp_pkg;

  // Input word commands; the fourth code is ignored.
  typedef enum logic [1:0] {
    CMD_BEGIN   = 2'd0,
    CMD_RX      = 2'd1,
    CMD_TIMEOUT = 2'd2
  } cmd_t;

  // Awaited reply selected by a begin word; other codes mean none.
  typedef enum logic [2:0] {
    REQ_NONE  = 3'd0,
    REQ_QUERY = 3'd1,
    REQ_POWER = 3'd2,
    REQ_READ  = 3'd3,
    REQ_CLEAR = 3'd4
  } req_t;

  // Result word event codes.
  typedef enum logic [3:0] {
    EV_NONE        = 4'd0,
    EV_CODE_BYTE   = 4'd1,
    EV_EMPTY_CODE  = 4'd2,
    EV_LIST_END    = 4'd3,
    EV_NONE_STORED = 4'd4,
    EV_NAME_BYTE   = 4'd5,
    EV_CLEAR_OK    = 4'd6,
    EV_CLEAR_BAD   = 4'd7,
    EV_POWER_OK    = 4'd8,
    EV_POWER_BAD   = 4'd9,
    EV_HEADER_BAD  = 4'd10,
    EV_IDLE_DROP   = 4'd11,
    EV_TIMEOUT     = 4'd12
  } ev_t;

  // Reply framing lengths and markers.
  localparam logic [4:0] HEADER_LEN  = 5'd11;
  localparam logic [4:0] QUERY_LEN   = 5'd25;
  localparam logic [4:0] ACK_LEN     = 5'd5;
  localparam logic [4:0] NAME_START  = 5'd5;
  localparam logic [4:0] TAG_FIRST   = 5'd2;
  localparam logic [4:0] TAG_LAST    = 5'd8;
  localparam logic [4:0] COUNT_HI    = 5'd9;
  localparam logic [7:0] NONE_STORED = 8'h05;

  // One parser result as it travels to the output register.
  typedef struct packed {
    logic       valid;
    ev_t        ev;
    logic [7:0] data;
    logic [7:0] ctype;
    logic       last;
    logic       done;
  } res_t;

  // "@MemoSc" tag found at header bytes 2 to 8.
  function automatic logic [7:0] header_tag(input logic [2:0] idx);
    logic [7:0] val;
    case (idx)
      3'd0:    val = 8'h40;
      3'd1:    val = 8'h4D;
      3'd2:    val = 8'h65;
      3'd3:    val = 8'h6D;
      3'd4:    val = 8'h6F;
      3'd5:    val = 8'h53;
      3'd6:    val = 8'h63;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

  // Five-byte acknowledge: ESC @ C for clear, ESC @ P for power-down.
  function automatic logic [7:0] ack_char(input logic is_power, input logic [2:0] idx);
    logic [7:0] val;
    case (idx)
      3'd0:    val = 8'h02;
      3'd1:    val = 8'h1B;
      3'd2:    val = 8'h40;
      3'd3:    val = is_power ? 8'h50 : 8'h43;
      3'd4:    val = is_power ? 8'h09 : 8'h1A;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

endpackage

/* rtl/core/srp_parser.sv */
// Parser state and the per-word reply decoding between the input and result registers.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module srp_parser (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               go,
  input  srp_pkg::cmd_t      cmd,
  input  srp_pkg::req_t      req,
  input  logic [7:0]         rx_byte,
  output srp_pkg::res_t      res
);

  typedef enum logic [3:0] {
    MODE_IDLE    = 4'd0,
    MODE_QUERY   = 4'd1,
    MODE_POWER   = 4'd2,
    MODE_HEADER  = 4'd3,
    MODE_LENGTH  = 4'd4,
    MODE_CONTENT = 4'd5,
    MODE_CLEAR   = 4'd6,
    MODE_ERROR   = 4'd7
  } mode_t;

  mode_t       mode_r, mode_nxt;
  logic [4:0]  pos_r, pos_nxt;
  logic [15:0] remain_r, remain_nxt;
  logic [7:0]  rlen_r, rlen_nxt;
  logic [7:0]  rpos_r, rpos_nxt;
  logic [7:0]  rtype_r, rtype_nxt;
  logic [7:0]  cnt_hi_r, cnt_hi_nxt;

  logic [4:0]  tag_idx;
  logic [15:0] remain_dec;
  logic [15:0] count_full;
  logic [7:0]  ack_exp;
  logic        finish;
  logic        go_idle;

  assign tag_idx    = pos_r - srp_pkg::TAG_FIRST;
  assign remain_dec = remain_r - 16'd1;
  assign count_full = {cnt_hi_r, rx_byte};
  assign ack_exp    = srp_pkg::ack_char(mode_r == MODE_POWER, pos_r[2:0]);

  always_comb begin
    mode_nxt   = mode_r;
    pos_nxt    = pos_r;
    remain_nxt = remain_r;
    rlen_nxt   = rlen_r;
    rpos_nxt   = rpos_r;
    rtype_nxt  = rtype_r;
    cnt_hi_nxt = cnt_hi_r;
    res        = '0;
    res.ev     = srp_pkg::EV_NONE;
    finish     = 1'b0;
    go_idle    = 1'b0;

    unique case (cmd)
      srp_pkg::CMD_BEGIN: begin
        go_idle = 1'b1;
      end
      srp_pkg::CMD_TIMEOUT: begin
        go_idle   = 1'b1;
        res.valid = 1'b1;
        res.ev    = srp_pkg::EV_TIMEOUT;
      end
      srp_pkg::CMD_RX: begin
        unique case (mode_r)
          MODE_IDLE: begin
            res.valid = 1'b1;
            res.ev    = srp_pkg::EV_IDLE_DROP;
            res.data  = rx_byte;
          end
          MODE_QUERY: begin
            if (pos_r < srp_pkg::NAME_START) begin
              pos_nxt = pos_r + 5'd1;
            end else begin
              res.valid = 1'b1;
              res.ev    = srp_pkg::EV_NAME_BYTE;
              res.data  = rx_byte;
              if (pos_r >= srp_pkg::QUERY_LEN - 5'd1) begin
                res.last = 1'b1;
                go_idle  = 1'b1;
              end else begin
                pos_nxt = pos_r + 5'd1;
              end
            end
          end
          MODE_POWER, MODE_CLEAR: begin
            if (pos_r >= srp_pkg::ACK_LEN || ack_exp != rx_byte) begin
              mode_nxt  = MODE_ERROR;
              res.valid = 1'b1;
              res.ev    = (mode_r == MODE_POWER) ? srp_pkg::EV_POWER_BAD
                                                 : srp_pkg::EV_CLEAR_BAD;
              res.data  = rx_byte;
            end else if (pos_r == srp_pkg::ACK_LEN - 5'd1) begin
              go_idle   = 1'b1;
              res.valid = 1'b1;
              res.ev    = (mode_r == MODE_POWER) ? srp_pkg::EV_POWER_OK
                                                 : srp_pkg::EV_CLEAR_OK;
            end else begin
              pos_nxt = pos_r + 5'd1;
            end
          end
          MODE_HEADER: begin
            if (pos_r == 5'd0 && rx_byte == srp_pkg::NONE_STORED) begin
              go_idle   = 1'b1;
              res.valid = 1'b1;
              res.ev    = srp_pkg::EV_NONE_STORED;
              res.done  = 1'b1;
            end else if (pos_r >= srp_pkg::TAG_FIRST && pos_r <= srp_pkg::TAG_LAST &&
                         srp_pkg::header_tag(tag_idx[2:0]) != rx_byte) begin
              mode_nxt  = MODE_ERROR;
              res.valid = 1'b1;
              res.ev    = srp_pkg::EV_HEADER_BAD;
              res.data  = rx_byte;
            end else if (pos_r >= srp_pkg::HEADER_LEN - 5'd1) begin
              if (count_full == 16'd0) begin
                go_idle   = 1'b1;
                res.valid = 1'b1;
                res.ev    = srp_pkg::EV_LIST_END;
                res.done  = 1'b1;
              end else begin
                remain_nxt = count_full;
                mode_nxt   = MODE_LENGTH;
                rpos_nxt   = 8'd0;
              end
            end else begin
              if (pos_r == srp_pkg::COUNT_HI) begin
                cnt_hi_nxt = rx_byte;
              end
              pos_nxt = pos_r + 5'd1;
            end
          end
          MODE_LENGTH: begin
            rlen_nxt  = rx_byte;
            rpos_nxt  = 8'd0;
            rtype_nxt = 8'd0;
            if (rx_byte == 8'd0) begin
              finish = 1'b1;
              res.ev = srp_pkg::EV_EMPTY_CODE;
            end else begin
              mode_nxt = MODE_CONTENT;
            end
          end
          MODE_CONTENT: begin
            if (rpos_r == 8'd0) begin
              rtype_nxt = rx_byte;
              if (rlen_r <= 8'd1) begin
                finish    = 1'b1;
                res.ev    = srp_pkg::EV_EMPTY_CODE;
                res.ctype = rx_byte;
              end else begin
                rpos_nxt = 8'd1;
              end
            end else begin
              res.valid = 1'b1;
              res.ev    = srp_pkg::EV_CODE_BYTE;
              res.data  = rx_byte;
              res.ctype = rtype_r;
              if (rpos_r >= rlen_r - 8'd1) begin
                finish = 1'b1;
              end else begin
                rpos_nxt = rpos_r + 8'd1;
              end
            end
          end
          default: begin
            // Sticky error: bytes are dropped silently until a begin or a timeout.
          end
        endcase
      end
      default: begin
      end
    endcase

    // A finished code counts down; the final one closes the list.
    if (finish) begin
      res.valid = 1'b1;
      res.last  = 1'b1;
      if (remain_dec == 16'd0) begin
        go_idle  = 1'b1;
        res.done = 1'b1;
      end else begin
        remain_nxt = remain_dec;
        mode_nxt   = MODE_LENGTH;
        rpos_nxt   = 8'd0;
      end
    end

    if (go_idle) begin
      mode_nxt   = MODE_IDLE;
      pos_nxt    = 5'd0;
      remain_nxt = 16'd0;
      rlen_nxt   = 8'd0;
      rpos_nxt   = 8'd0;
      rtype_nxt  = 8'd0;
      cnt_hi_nxt = 8'd0;
    end

    if (cmd == srp_pkg::CMD_BEGIN) begin
      case (req)
        srp_pkg::REQ_QUERY: mode_nxt = MODE_QUERY;
        srp_pkg::REQ_POWER: mode_nxt = MODE_POWER;
        srp_pkg::REQ_READ:  mode_nxt = MODE_HEADER;
        srp_pkg::REQ_CLEAR: mode_nxt = MODE_CLEAR;
        default:            mode_nxt = MODE_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_IDLE;
      pos_r    <= 5'd0;
      remain_r <= 16'd0;
      rlen_r   <= 8'd0;
      rpos_r   <= 8'd0;
      rtype_r  <= 8'd0;
      cnt_hi_r <= 8'd0;
    end else if (go) begin
      mode_r   <= mode_nxt;
      pos_r    <= pos_nxt;
      remain_r <= remain_nxt;
      rlen_r   <= rlen_nxt;
      rpos_r   <= rpos_nxt;
      rtype_r  <= rtype_nxt;
      cnt_hi_r <= cnt_hi_nxt;
    end
  end

  `SRP_ASSERT(a_timeout_idles, clk, rst_n, (go && cmd == srp_pkg::CMD_TIMEOUT) |=> (mode_r == MODE_IDLE && remain_r == 16'd0), "timeout did not return the parser to idle")
  `SRP_ASSERT(a_records_counted, clk, rst_n, (mode_r == MODE_LENGTH || mode_r == MODE_CONTENT) |-> (remain_r != 16'd0), "record parsing with no codes remaining")
  `SRP_ASSERT(a_last_kind, clk, rst_n, res.last |-> (res.ev == srp_pkg::EV_CODE_BYTE || res.ev == srp_pkg::EV_EMPTY_CODE || res.ev == srp_pkg::EV_NAME_BYTE), "end of run marked on a non-run event")

endmodule

/* rtl/core/scanner_response_parser_core.sv */
// Top level of the scanner response parser: input register, parser and result register.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Byte-wise parser for a handheld scanner's serial replies. A begin word (tuser 0) selects the
// awaited reply (query, power-down, read codes or clear); each received-byte word (tuser 1) then
// advances the parser, and a timeout word (tuser 2) aborts to idle with a timeout event. A read
// reply is checked against its 11-byte header and then split into records whose content bytes
// stream out with their type byte; tlast marks the final byte of a code or of the device name, and
// the list-done flag marks the word that ends the list. Each input word gives at most one output
// word. The block accepts one word per clock cycle while the result register is free or being
// emptied. The parser state lives in a single set of registers updated in the cycle a word leaves
// the input register, so the only loop is that state update. A result passes from the input
// register through the parser into the result register, which offers it to the receiver.
// The input register stalls only while a result sits unaccepted in the output register.

module scanner_response_parser_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [2:0] expect_req, [10:3] rx_byte, [15:11] zero
  input  logic [1:0]  in_tuser,   // [1:0] cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] data_byte, [15:8] code_type
  output logic [4:0]  out_tuser,  // [3:0] event_res, [4] list_done
  output logic        out_tlast   // last_of_run
);

  // Input register.
  logic           in_v_r;
  srp_pkg::cmd_t  cmd_r;
  srp_pkg::req_t  req_r;
  logic [7:0]     byte_r;

  // Result register.
  logic           out_v_r;
  srp_pkg::ev_t   ev_r;
  logic [7:0]     data_r;
  logic [7:0]     ctype_r;
  logic           last_r;
  logic           done_r;

  srp_pkg::res_t  res;
  logic           adv;

  // A word moves on when the result register is free or being emptied this cycle.
  assign adv       = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !in_v_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_tready) begin
        in_v_r <= in_tvalid;
      end
      if (adv) begin
        out_v_r <= res.valid;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      cmd_r  <= srp_pkg::cmd_t'(in_tuser);
      req_r  <= srp_pkg::req_t'(in_tdata[2:0]);
      byte_r <= in_tdata[10:3];
    end
    if (adv) begin
      ev_r    <= res.ev;
      data_r  <= res.data;
      ctype_r <= res.ctype;
      last_r  <= res.last;
      done_r  <= res.done;
    end
  end

  srp_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .go      (adv),
    .cmd     (cmd_r),
    .req     (req_r),
    .rx_byte (byte_r),
    .res     (res)
  );

  assign out_tvalid = out_v_r;
  assign out_tdata  = {ctype_r, data_r};
  assign out_tuser  = {done_r, ev_r};
  assign out_tlast  = last_r;

  `SRP_ASSERT(a_done_kind, clk, rst_n,
    (out_v_r && done_r) |-> (ev_r == srp_pkg::EV_CODE_BYTE || ev_r == srp_pkg::EV_EMPTY_CODE ||
                             ev_r == srp_pkg::EV_LIST_END || ev_r == srp_pkg::EV_NONE_STORED),
    "list end flagged on an unrelated event")
  `SRP_ASSERT(a_no_none_event, clk, rst_n,
    out_v_r |-> (ev_r != srp_pkg::EV_NONE),
    "result word carries no event")
  `SRP_ASSERT_ALWAYS(a_reset_empty, clk,
    !rst_n |=> (!out_tvalid && in_tready),
    "pipeline not empty after reset")

endmodule
